// ===== design/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Types, widths and helpers shared by the closest-point-on-polygon block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

  localparam int CW  = 32;          // coordinate width
  localparam int DW  = CW + 1;      // coordinate difference width
  localparam int PW  = 2 * CW + 1;  // square of a difference magnitude
  localparam int SW  = 2 * CW + 2;  // sum of two squares
  localparam int RW  = SW + 2;      // divider partial remainder
  localparam int CNW = $clog2(DW);  // divider bit index
  localparam int EW  = 16;          // near_epsilon width

  localparam logic [EW-1:0] EPS_RESET = EW'(1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   last_edge;
  } in_item_t;

  typedef struct packed {
    coord_t      nearest_x;
    coord_t      nearest_y;
    logic [63:0] nearest_dist_sq;
  } out_item_t;

  typedef enum logic [1:0] {
    K_END,
    K_START,
    K_PROJ
  } kind_t;

  // one classified edge handed from the front to the back
  typedef struct packed {
    kind_t          kind;
    logic           last;
    coord_t         px;
    coord_t         py;
    coord_t         sx;
    coord_t         sy;
    coord_t         ex;
    coord_t         ey;
    diff_t          dx;
    diff_t          dy;
    logic [SW-1:0]  dot;
    logic [SW-1:0]  len;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_CLS
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_RND,
    B_MUL,
    B_SUM,
    B_UPD
  } back_state_t;

  function automatic logic [DW-1:0] mag(input diff_t v);
    logic [DW-1:0] r;
    r = v[DW-1] ? DW'(-v) : DW'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cpp_queue.sv =====
// ----------------------------------------------------------------------------
// cpp_queue
// Two-entry queue of classified edges between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  cpp_pkg::job_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output cpp_pkg::job_t      pop_data,
  output logic               empty
);
  import cpp_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== design/cpp_front.sv =====
// ----------------------------------------------------------------------------
// cpp_front
// Accepts an edge, forms distances, edge length and projection dot product,
// and classifies the edge as end point, start point or projection.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  cpp_pkg::in_item_t            in_data,
  input  wire logic [cpp_pkg::EW-1:0]  near_epsilon,
  output logic                         q_push,
  output cpp_pkg::job_t                q_data,
  input  wire logic                    q_full
);
  import cpp_pkg::*;

  front_state_t state_r, state_nxt;

  in_item_t item_r;
  diff_t    dex_r, dey_r, dsx_r, dsy_r, dx_r, dy_r;
  logic [PW-1:0] sq_ex_r, sq_ey_r, sq_sx_r, sq_sy_r, sq_dx_r, sq_dy_r;
  logic signed [SW-1:0] dot_x_r, dot_y_r;
  logic [2*EW-1:0] e2_r;
  logic [SW-1:0] d_end_r, d_start_r, len_r;
  logic signed [SW:0] dot_r;

  logic [DW-1:0] m_ex, m_ey, m_sx, m_sy, m_dx, m_dy;
  diff_t psx, psy;
  logic [SW-1:0] e2_w;
  kind_t kind;

  assign m_ex = mag(dex_r);
  assign m_ey = mag(dey_r);
  assign m_sx = mag(dsx_r);
  assign m_sy = mag(dsy_r);
  assign m_dx = mag(dx_r);
  assign m_dy = mag(dy_r);
  assign psx  = -dsx_r;
  assign psy  = -dsy_r;
  assign e2_w = {{(SW-2*EW){1'b0}}, e2_r};

  always_comb begin
    if (d_end_r < e2_w) begin
      kind = K_END;
    end else if (d_start_r < e2_w) begin
      kind = K_START;
    end else if ((len_r < e2_w) || (len_r == '0)) begin
      kind = K_START;
    end else if (!dot_r[SW] && (dot_r[SW-1:0] <= len_r)) begin
      kind = K_PROJ;
    end else if (d_start_r < d_end_r) begin
      kind = K_START;
    end else begin
      kind = K_END;
    end
  end

  always_comb begin
    q_data.kind = kind;
    q_data.last = item_r.last_edge;
    q_data.px   = item_r.query_x;
    q_data.py   = item_r.query_y;
    q_data.sx   = item_r.start_x;
    q_data.sy   = item_r.start_y;
    q_data.ex   = item_r.end_x;
    q_data.ey   = item_r.end_y;
    q_data.dx   = dx_r;
    q_data.dy   = dy_r;
    q_data.dot  = dot_r[SW-1:0];
    q_data.len  = len_r;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = F_MUL;
      end
      F_MUL: state_nxt = F_SUM;
      F_SUM: state_nxt = F_CLS;
      F_CLS: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        item_r <= in_data;
        dex_r  <= DW'(in_data.end_x)   - DW'(in_data.query_x);
        dey_r  <= DW'(in_data.end_y)   - DW'(in_data.query_y);
        dsx_r  <= DW'(in_data.start_x) - DW'(in_data.query_x);
        dsy_r  <= DW'(in_data.start_y) - DW'(in_data.query_y);
        dx_r   <= DW'(in_data.end_x)   - DW'(in_data.start_x);
        dy_r   <= DW'(in_data.end_y)   - DW'(in_data.start_y);
      end
      F_MUL: begin
        sq_ex_r <= PW'(m_ex) * PW'(m_ex);
        sq_ey_r <= PW'(m_ey) * PW'(m_ey);
        sq_sx_r <= PW'(m_sx) * PW'(m_sx);
        sq_sy_r <= PW'(m_sy) * PW'(m_sy);
        sq_dx_r <= PW'(m_dx) * PW'(m_dx);
        sq_dy_r <= PW'(m_dy) * PW'(m_dy);
        dot_x_r <= SW'(dx_r) * SW'(psx);
        dot_y_r <= SW'(dy_r) * SW'(psy);
        e2_r    <= near_epsilon * near_epsilon;
      end
      F_SUM: begin
        d_end_r   <= {1'b0, sq_ex_r} + {1'b0, sq_ey_r};
        d_start_r <= {1'b0, sq_sx_r} + {1'b0, sq_sy_r};
        len_r     <= {1'b0, sq_dx_r} + {1'b0, sq_dy_r};
        dot_r     <= {dot_x_r[SW-1], dot_x_r} + {dot_y_r[SW-1], dot_y_r};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cpp_back.sv =====
// ----------------------------------------------------------------------------
// cpp_back
// Carries out a classified edge: bit-serial projection divide, distance of
// the chosen point, running minimum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  cpp_pkg::job_t      q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cpp_pkg::out_item_t out_data
);
  import cpp_pkg::*;

  back_state_t state_r, state_nxt;

  job_t          job_r;
  logic [DW-1:0] mx_r, my_r;
  logic [RW-1:0] rx_r, ry_r;
  logic [DW-1:0] qx_r, qy_r;
  logic [CNW-1:0] cnt_r;
  coord_t        cx_r, cy_r;
  logic [PW-1:0] sqx_r, sqy_r;
  logic [63:0]   dsat_r;

  logic [63:0]   best_dist_r;
  coord_t        best_x_r, best_y_r;
  logic          have_best_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  // one restoring step per cycle for each coordinate
  function automatic logic [RW+DW-1:0] div_step(input logic [RW-1:0] r,
                                               input logic [DW-1:0] q,
                                               input logic          b,
                                               input logic [SW-1:0] num,
                                               input logic [SW-1:0] den);
    logic [RW-1:0] t, d1, d2;
    logic [DW-1:0] qn;
    t  = {r[RW-2:0], 1'b0} + (b ? RW'(num) : RW'(0));
    d1 = RW'(den);
    d2 = {d1[RW-2:0], 1'b0};
    qn = {q[DW-2:0], 1'b0};
    if (t >= d2) begin
      t  = t - d2;
      qn = qn + DW'(2);
    end else if (t >= d1) begin
      t  = t - d1;
      qn = qn + DW'(1);
    end
    return {t, qn};
  endfunction

  logic [RW+DW-1:0] step_x, step_y;
  logic [DW-1:0] qx_rnd, qy_rnd;
  logic signed [CW+1:0] ox, oy, cx_full, cy_full;
  diff_t ddx, ddy;
  logic [DW-1:0] m_ddx, m_ddy;
  logic [SW-1:0] dist_sum;
  logic take, out_free;
  logic [63:0] nb_dist;
  coord_t nb_x, nb_y;

  assign step_x = div_step(rx_r, qx_r, mx_r[cnt_r], job_r.dot, job_r.len);
  assign step_y = div_step(ry_r, qy_r, my_r[cnt_r], job_r.dot, job_r.len);

  // round to nearest, ties away from zero
  assign qx_rnd = qx_r + DW'({rx_r[RW-2:0], 1'b0} >= RW'(job_r.len));
  assign qy_rnd = qy_r + DW'({ry_r[RW-2:0], 1'b0} >= RW'(job_r.len));
  assign ox = job_r.dx[DW-1] ? -$signed({1'b0, qx_rnd}) : $signed({1'b0, qx_rnd});
  assign oy = job_r.dy[DW-1] ? -$signed({1'b0, qy_rnd}) : $signed({1'b0, qy_rnd});
  assign cx_full = {{2{job_r.sx[CW-1]}}, job_r.sx} + ox;
  assign cy_full = {{2{job_r.sy[CW-1]}}, job_r.sy} + oy;

  assign ddx      = DW'(cx_r) - DW'(job_r.px);
  assign ddy      = DW'(cy_r) - DW'(job_r.py);
  assign m_ddx    = mag(ddx);
  assign m_ddy    = mag(ddy);
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign take     = !have_best_r || (dsat_r < best_dist_r);
  assign nb_dist  = take ? dsat_r : best_dist_r;
  assign nb_x     = take ? cx_r : best_x_r;
  assign nb_y     = take ? cy_r : best_y_r;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = (q_data.kind == K_PROJ) ? B_DIV : B_MUL;
        end
      end
      B_DIV:   if (cnt_r == '0) state_nxt = B_RND;
      B_RND:   state_nxt = B_MUL;
      B_MUL:   state_nxt = B_SUM;
      B_SUM:   state_nxt = B_UPD;
      B_UPD:   if (!job_r.last || out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      have_best_r <= 1'b0;
      best_dist_r <= '1;
      best_x_r    <= '0;
      best_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_UPD) && job_r.last && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == B_UPD) begin
        if (!job_r.last) begin
          have_best_r <= 1'b1;
          best_dist_r <= nb_dist;
          best_x_r    <= nb_x;
          best_y_r    <= nb_y;
        end else if (out_free) begin
          have_best_r <= 1'b0;
          best_dist_r <= '1;
          best_x_r    <= '0;
          best_y_r    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r <= q_data;
        mx_r  <= mag(q_data.dx);
        my_r  <= mag(q_data.dy);
        rx_r  <= '0;
        ry_r  <= '0;
        qx_r  <= '0;
        qy_r  <= '0;
        cnt_r <= CNW'(DW - 1);
        cx_r  <= (q_data.kind == K_END) ? q_data.ex : q_data.sx;
        cy_r  <= (q_data.kind == K_END) ? q_data.ey : q_data.sy;
      end
      B_DIV: begin
        rx_r  <= step_x[RW+DW-1:DW];
        qx_r  <= step_x[DW-1:0];
        ry_r  <= step_y[RW+DW-1:DW];
        qy_r  <= step_y[DW-1:0];
        cnt_r <= cnt_r - CNW'(1);
      end
      B_RND: begin
        cx_r <= cx_full[CW-1:0];
        cy_r <= cy_full[CW-1:0];
      end
      B_MUL: begin
        sqx_r <= PW'(m_ddx) * PW'(m_ddx);
        sqy_r <= PW'(m_ddy) * PW'(m_ddy);
      end
      B_SUM: begin
        dsat_r <= (dist_sum[SW-1:64] != '0) ? '1 : dist_sum[63:0];
      end
      B_UPD: begin
        if (job_r.last && out_free) begin
          out_data_r.nearest_x       <= nb_x;
          out_data_r.nearest_y       <= nb_y;
          out_data_r.nearest_dist_sq <= nb_dist;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/closest_point_on_polygon.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_polygon
// Nearest point on a polygon boundary, one edge per input transaction.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   in_      | input     | in_valid/in_ready  | query point, edge, last_edge
//   out_     | output    | out_valid/out_ready| nearest point, squared distance
//   cfg_     | input     | cfg_we             | near_epsilon
//
// the front takes a new edge only once the last one has gone into the queue;
// the back takes no new edge until it is done with the last: an end point or
// start point edge skips the divider, a projected edge also runs the 33-step
// bit-serial divider and a rounding step. a result waits in the output register
// while the back goes on with the next polygon up to its last edge. synchronous
// reset clears control, the kept point and sets near_epsilon to 1
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_polygon (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  cpp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output cpp_pkg::out_item_t           out_data,
  input  wire logic                    cfg_we,
  input  wire logic [cpp_pkg::EW-1:0]  cfg_wdata
);
  import cpp_pkg::*;

  logic [EW-1:0] near_epsilon_r;
  job_t          push_data, pop_data;
  logic          push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_epsilon_r <= EPS_RESET;
    end else if (cfg_we) begin
      near_epsilon_r <= cfg_wdata;
    end
  end

  cpp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .near_epsilon (near_epsilon_r),
    .q_push       (push),
    .q_data       (push_data),
    .q_full       (full)
  );

  cpp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (pop_data),
    .q_empty   (empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams polygon edges with random gaps into closest_point_on_polygon and
// compares each emitted nearest point and squared distance against a
// fixed-point predictor, across several near_epsilon settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import cpp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [EW-1:0] cfg_wdata = '0;

  closest_point_on_polygon i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  in_item_t edge_queue[$];
  out_item_t nearest_expected[$];
  logic [EW-1:0] eps_model;
  logic [63:0] kept_dist;
  coord_t kept_x, kept_y;
  logic kept_valid;
  int errors = 0;
  int calm = 0;
  longint cycles = 0;
  logic send_hold = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // round(d * num / den), ties away from zero
  function automatic longint scale_offset(longint d, logic [127:0] num, logic [127:0] den);
    logic [127:0] m, q, r;
    m = (d < 0) ? -d : d;
    q = (m * num) / den;
    r = (m * num) % den;
    if ((r << 1) >= den) q = q + 1;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [127:0] sqsum(longint ax, longint ay);
    logic signed [127:0] x, y;
    x = ax;
    y = ay;
    return x * x + y * y;
  endfunction

  task automatic predict_edge(input in_item_t it);
    longint px, py, sx, sy, ex, ey, cx, cy, dx, dy;
    logic [127:0] e2, d_end, d_start, len, dist_full;
    logic signed [127:0] dot;
    logic [63:0] dsat;
    out_item_t r;
    px = it.query_x; py = it.query_y; sx = it.start_x;
    sy = it.start_y; ex = it.end_x; ey = it.end_y;
    e2 = eps_model * eps_model;
    d_end = sqsum(ex - px, ey - py);
    d_start = sqsum(sx - px, sy - py);
    dx = ex - sx;
    dy = ey - sy;
    len = sqsum(dx, dy);
    if (d_end < e2) begin
      cx = ex; cy = ey;
    end else if (d_start < e2) begin
      cx = sx; cy = sy;
    end else if (len < e2 || len == 0) begin
      cx = sx; cy = sy;
    end else begin
      dot = 128'(signed'(dx)) * 128'(signed'(px - sx)) + 128'(signed'(dy)) * 128'(signed'(py - sy));
      if (dot >= 0 && dot <= $signed(len)) begin
        cx = sx + scale_offset(dx, dot, len);
        cy = sy + scale_offset(dy, dot, len);
      end else if (d_start < d_end) begin
        cx = sx; cy = sy;
      end else begin
        cx = ex; cy = ey;
      end
    end
    dist_full = sqsum(cx - px, cy - py);
    dsat = (dist_full[127:64] != 0) ? '1 : dist_full[63:0];
    if (!kept_valid || dsat < kept_dist) begin
      kept_dist = dsat;
      kept_x = coord_t'(cx);
      kept_y = coord_t'(cy);
      kept_valid = 1'b1;
    end
    if (it.last_edge) begin
      r.nearest_x = kept_x;
      r.nearest_y = kept_y;
      r.nearest_dist_sq = kept_dist;
      nearest_expected.push_back(r);
      kept_dist = '1; kept_x = '0; kept_y = '0; kept_valid = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (calm > 0) calm <= calm - 1;
    else if ($urandom_range(0, 999) == 0) calm <= 2000;
    if (!in_valid || in_ready) begin
      // under hold, each polygon waits until every earlier result is back
      if (rst_n && (!send_hold || nearest_expected.size() == 0) &&
          edge_queue.size() != 0 &&
          (calm > 0 || $urandom_range(0, 99) >= 7)) begin
        in_data <= edge_queue[0];
        predict_edge(edge_queue.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (nearest_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors <= errors + 1;
      end else begin
        if (out_data !== nearest_expected[0]) begin
          $display("%0t: mismatch expected x=%h y=%h d=%h actual x=%h y=%h d=%h", $time,
                   nearest_expected[0].nearest_x, nearest_expected[0].nearest_y,
                   nearest_expected[0].nearest_dist_sq, out_data.nearest_x,
                   out_data.nearest_y, out_data.nearest_dist_sq);
          errors <= errors + 1;
        end
        void'(nearest_expected.pop_front());
      end
    end
    out_ready <= rst_n && (calm > 0 || $urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      default: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic in_item_t rnd_edge(int mode, logic last, coord_t qx, coord_t qy);
    in_item_t it;
    it.query_x = qx; it.query_y = qy;
    it.start_x = rnd_coord(mode); it.start_y = rnd_coord(mode);
    it.end_x = rnd_coord(mode); it.end_y = rnd_coord(mode);
    case ($urandom_range(0, 9))
      0: begin it.end_x = it.start_x; it.end_y = it.start_y; end
      1: begin it.end_x = qx + coord_t'($urandom_range(0, 3)); it.end_y = qy; end
      2: begin it.start_x = qx; it.start_y = qy - coord_t'($urandom_range(0, 3)); end
      default: ;
    endcase
    it.last_edge = last;
    return it;
  endfunction

  task automatic wait_drained();
    while (edge_queue.size() != 0 || in_valid || nearest_expected.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_eps(input logic [EW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_model = v;
  endtask

  task automatic add_polygons(input int n_items, input int mode);
    int k, sides;
    coord_t qx, qy;
    k = 0;
    while (k < n_items) begin
      sides = $urandom_range(1, 6);
      qx = rnd_coord(mode == 3 ? $urandom_range(0, 2) : mode);
      qy = rnd_coord(mode == 3 ? $urandom_range(0, 2) : mode);
      for (int s = 0; s < sides; s++)
        edge_queue.push_back(rnd_edge(mode == 3 ? $urandom_range(0, 2) : mode,
                                      s == sides - 1, qx, qy));
      k += sides;
    end
  endtask

  initial begin
    in_item_t it;
    logic [EW-1:0] eps_set[5] = '{16'd0, 16'hffff, 16'd300, 16'd1, 16'd40};
    eps_model = EPS_RESET;
    kept_dist = '1; kept_x = '0; kept_y = '0; kept_valid = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, degenerate edge, projection, coincident points
    it = '0; it.last_edge = 1'b1;
    edge_queue.push_back(it);
    it.query_x = 32'h7fffffff; it.query_y = 32'h80000000;
    it.start_x = 32'h80000000; it.start_y = 32'h7fffffff;
    it.end_x = 32'h80000000; it.end_y = 32'h7fffffff; it.last_edge = 1'b0;
    edge_queue.push_back(it);
    it.end_x = 32'h7fffffff; it.end_y = 32'h80000000; it.last_edge = 1'b1;
    edge_queue.push_back(it);
    it = '0; it.query_x = 32'h00010000; it.query_y = 32'h00050000;
    it.start_x = 32'hfffb0000; it.end_x = 32'h00050000; it.last_edge = 1'b0;
    edge_queue.push_back(it);
    it.start_x = 32'h00200000; it.end_x = 32'h00300000; it.last_edge = 1'b1;
    edge_queue.push_back(it);
    it = '0; it.query_x = 32'h0; it.start_x = 32'hffff0000; it.end_x = 32'h00010000;
    it.start_y = 32'h00030000; it.end_y = 32'h00030000; it.last_edge = 1'b1;
    edge_queue.push_back(it);
    for (int j = 0; j < 12; j++)
      edge_queue.push_back(rnd_edge(j % 3, j % 4 == 3 || j == 11, 32'h0, 32'h1));
    wait_drained();
    for (int p = 0; p < 5; p++) begin
      write_eps(eps_set[p]);
      add_polygons(80, p % 3);
      add_polygons(80, 3);
      send_hold <= (p == 2);
      wait_drained();
      send_hold <= 1'b0;
    end
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
